@@ hw/rtl/rshd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the ray sphere hit block
package rshd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEALTH = 3'd4;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [15:0] HEALTH_RESET = 16'd25600;

    // action codes
    localparam logic ACT_SHOT  = 1'b0;
    localparam logic ACT_RESET = 1'b1;

    // arithmetic layout
    localparam int DIR_FRAC    = 14;
    localparam int DISC_SHIFT  = 28;
    localparam int ROOT_STEPS  = 51;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               action;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [30:0]        max_range;
        logic [15:0]        damage;
    } shot_t;

    typedef struct packed {
        logic        hit;
        logic        eliminated;
        logic [30:0] hit_distance;
        logic [15:0] damage_applied;
        logic [15:0] health_left;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } cfg_wr_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
        logic [15:0]        max_health;
    } cfg_regs_t;

    typedef enum logic {
        CMD_SHOT,
        CMD_RESET
    } cmd_t;

    // queue entry: classified item with origin already made relative to the center
    typedef struct packed {
        cmd_t               cmd;
        logic signed [32:0] off_x;
        logic signed [32:0] off_y;
        logic signed [32:0] off_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [30:0]        max_range;
        logic [15:0]        damage;
    } work_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ABS,
        ST_SQP,
        ST_DISC,
        ST_CMP,
        ST_ROOT,
        ST_DIST,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/rshd_chan_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel carrying one payload type
interface rshd_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/rshd_front.sv @@
`timescale 1ns / 1ps
// front stage: takes items, classifies them and offsets the origin
module rshd_front (
    input  logic                clk,
    input  logic                rst_n,
    rshd_chan_if.sink           shot,
    input  rshd_pkg::cfg_regs_t cfg_regs,
    output logic                push,
    output rshd_pkg::work_t     push_data,
    input  logic                q_full
);
    logic            fv_reg;
    rshd_pkg::work_t ent_reg;
    rshd_pkg::work_t ent_next;
    logic            take;

    assign push      = fv_reg && !q_full;
    assign shot.ready = !fv_reg || push;
    assign take      = shot.valid && shot.ready;
    assign push_data = ent_reg;

    always_comb
    begin
        ent_next.cmd       = (shot.data.action == rshd_pkg::ACT_RESET) ?
                             rshd_pkg::CMD_RESET : rshd_pkg::CMD_SHOT;
        ent_next.off_x     = 33'(shot.data.origin_x) - 33'(cfg_regs.center_x);
        ent_next.off_y     = 33'(shot.data.origin_y) - 33'(cfg_regs.center_y);
        ent_next.off_z     = 33'(shot.data.origin_z) - 33'(cfg_regs.center_z);
        ent_next.dir_x     = shot.data.dir_x;
        ent_next.dir_y     = shot.data.dir_y;
        ent_next.dir_z     = shot.data.dir_z;
        ent_next.max_range = shot.data.max_range;
        ent_next.damage    = shot.data.damage;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (take)
            fv_reg <= 1'b1;
        else if (push)
            fv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            ent_reg <= ent_next;
    end
endmodule

@@ hw/rtl/rshd_queue.sv @@
`timescale 1ns / 1ps
// short queue between front and back
module rshd_queue #(
    parameter int DEPTH = rshd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rshd_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output rshd_pkg::work_t pop_data,
    output logic            not_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rshd_pkg::work_t  mem [DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end
endmodule

@@ hw/rtl/rshd_back.sv @@
`timescale 1ns / 1ps
// back stage: intersection arithmetic, target state and result register
module rshd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rshd_pkg::cfg_regs_t cfg_regs,
    input  logic                q_not_empty,
    input  rshd_pkg::work_t     q_data,
    output logic                pop,
    rshd_chan_if.source         result
);
    rshd_pkg::state_t state_reg, state_next;
    rshd_pkg::work_t  e_reg;

    logic signed [48:0]  px_reg, py_reg, pz_reg;
    logic [64:0]         sx_reg, sy_reg, sz_reg;
    logic [61:0]         rr_reg;
    logic signed [50:0]  b_reg;
    logic [65:0]         q_reg;
    logic [49:0]         mb_reg;
    logic [49:0]         hh_reg, hl_reg, ll_reg;
    logic [101:0]        p_reg;
    logic [101:0]        rad_reg;
    logic [52:0]         rem_reg;
    logic [50:0]         root_reg;
    logic [5:0]          cnt_reg;
    logic signed [52:0]  d_reg;
    logic                miss_reg;

    logic [15:0]         health_reg;
    logic [15:0]         hits_reg;
    logic                dead_reg;

    logic                ov_reg;
    rshd_pkg::result_t   od_reg;

    // control signals of the sequencer
    logic                finish;
    logic                slot_free;

    // datapath helpers
    logic signed [65:0]  sqx, sqy, sqz;
    logic [102:0]        diff;
    logic [54:0]         rem_t, trial, rem_sub;
    logic signed [52:0]  nb, s53, d1;
    logic                in_rng, hit;
    logic [15:0]         health_hit;

    assign slot_free    = !ov_reg || result.ready;
    assign result.valid = ov_reg;
    assign result.data  = od_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rshd_pkg::ST_IDLE:
                if (q_not_empty)
                    state_next = (q_data.cmd == rshd_pkg::CMD_RESET) ?
                                 rshd_pkg::ST_DONE : rshd_pkg::ST_MUL;
            rshd_pkg::ST_MUL:  state_next = rshd_pkg::ST_SUM;
            rshd_pkg::ST_SUM:  state_next = rshd_pkg::ST_ABS;
            rshd_pkg::ST_ABS:  state_next = rshd_pkg::ST_SQP;
            rshd_pkg::ST_SQP:  state_next = rshd_pkg::ST_DISC;
            rshd_pkg::ST_DISC: state_next = rshd_pkg::ST_CMP;
            rshd_pkg::ST_CMP:
                state_next = diff[102] ? rshd_pkg::ST_DONE : rshd_pkg::ST_ROOT;
            rshd_pkg::ST_ROOT:
                if (cnt_reg == 6'(rshd_pkg::ROOT_STEPS - 1))
                    state_next = rshd_pkg::ST_DIST;
            rshd_pkg::ST_DIST: state_next = rshd_pkg::ST_DONE;
            rshd_pkg::ST_DONE:
                if (slot_free)
                    state_next = rshd_pkg::ST_IDLE;
            default:           state_next = rshd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop    = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            rshd_pkg::ST_IDLE: pop    = q_not_empty;
            rshd_pkg::ST_DONE: finish = slot_free;
            default:
            begin
                pop    = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sqx     = e_reg.off_x * e_reg.off_x;
        sqy     = e_reg.off_y * e_reg.off_y;
        sqz     = e_reg.off_z * e_reg.off_z;
        diff    = 103'(p_reg) - (103'(q_reg) << rshd_pkg::DISC_SHIFT);
        rem_t   = {rem_reg, rad_reg[101:100]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_t - trial;
        nb      = -53'(b_reg);
        s53     = 53'({2'b00, root_reg});
        d1      = nb - s53;
        in_rng  = !d_reg[52] &&
                  (d_reg[51:0] <= 52'({e_reg.max_range, 14'd0}));
        hit     = (e_reg.cmd == rshd_pkg::CMD_SHOT) && !miss_reg && !dead_reg && in_rng;
        health_hit = (e_reg.damage >= health_reg) ? 16'd0 : health_reg - e_reg.damage;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rshd_pkg::ST_IDLE;
            health_reg <= rshd_pkg::HEALTH_RESET;
            hits_reg   <= '0;
            dead_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                ov_reg <= 1'b1;
            else if (result.ready)
                ov_reg <= 1'b0;
            if (finish)
            begin
                if (e_reg.cmd == rshd_pkg::CMD_RESET)
                begin
                    health_reg <= cfg_regs.max_health;
                    hits_reg   <= '0;
                    dead_reg   <= 1'b0;
                end
                else if (hit)
                begin
                    health_reg <= health_hit;
                    hits_reg   <= hits_reg + 1'b1;
                    dead_reg   <= (health_hit == 16'd0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_reg    <= q_data;
            miss_reg <= 1'b0;
        end
        unique case (state_reg)
            rshd_pkg::ST_MUL:
            begin
                px_reg <= e_reg.off_x * e_reg.dir_x;
                py_reg <= e_reg.off_y * e_reg.dir_y;
                pz_reg <= e_reg.off_z * e_reg.dir_z;
                sx_reg <= sqx[64:0];
                sy_reg <= sqy[64:0];
                sz_reg <= sqz[64:0];
                rr_reg <= 62'(cfg_regs.sphere_radius) * 62'(cfg_regs.sphere_radius);
            end
            rshd_pkg::ST_SUM:
            begin
                b_reg <= 51'(px_reg) + 51'(py_reg) + 51'(pz_reg);
                q_reg <= 66'(sx_reg) + 66'(sy_reg) + 66'(sz_reg);
            end
            rshd_pkg::ST_ABS:
                mb_reg <= b_reg[50] ? 50'(-b_reg) : 50'(b_reg);
            rshd_pkg::ST_SQP:
            begin
                // square of |b| in 25-bit halves
                hh_reg <= 50'(mb_reg[49:25]) * 50'(mb_reg[49:25]);
                hl_reg <= 50'(mb_reg[49:25]) * 50'(mb_reg[24:0]);
                ll_reg <= 50'(mb_reg[24:0]) * 50'(mb_reg[24:0]);
            end
            rshd_pkg::ST_DISC:
                p_reg <= (102'(hh_reg) << 50) + (102'(hl_reg) << 26) + 102'(ll_reg)
                         + (102'(rr_reg) << rshd_pkg::DISC_SHIFT);
            rshd_pkg::ST_CMP:
            begin
                miss_reg <= diff[102];
                rad_reg  <= diff[101:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            rshd_pkg::ST_ROOT:
            begin
                // one result bit per cycle
                rad_reg <= {rad_reg[99:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (!rem_sub[54])
                begin
                    rem_reg  <= rem_sub[52:0];
                    root_reg <= {root_reg[49:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t[52:0];
                    root_reg <= {root_reg[49:0], 1'b0};
                end
            end
            rshd_pkg::ST_DIST:
                d_reg <= d1[52] ? nb + s53 : d1;
            default:
            begin
            end
        endcase
        if (finish)
        begin
            od_reg.hit            <= hit;
            od_reg.eliminated     <= hit && (health_hit == 16'd0);
            od_reg.hit_distance   <= hit ? d_reg[44:rshd_pkg::DIR_FRAC] : 31'd0;
            od_reg.damage_applied <= hit ? e_reg.damage : 16'd0;
            if (e_reg.cmd == rshd_pkg::CMD_RESET)
                od_reg.health_left <= cfg_regs.max_health;
            else
                od_reg.health_left <= hit ? health_hit : health_reg;
        end
    end
endmodule

@@ hw/rtl/ray_sphere_hit_with_damage.sv @@
`timescale 1ns / 1ps
// top level of the ray shot against a damageable sphere target
//
// channels: shot (input items), result (one result per item), cfg (register
// writes, index and value). each moves one transfer when valid and ready are
// both high. cfg is always ready and must only be written while idle.
// the front registers an item, marks it as shot or target reset and makes the
// origin relative to the sphere center; a two-entry queue hands it to the back.
// the back runs a sequencer: products, |b| squared in halves, discriminant,
// a bit-per-cycle square root of 51 steps, root choice and the state update.
// the back handles one item at a time: a shot runs the square root loop
// unless its discriminant is negative, and a target reset skips the
// arithmetic. the front keeps accepting until the queue and its own
// register are full.
// reset: config registers, health (100.0), hit count and flags return to
// their defaults, and all queues empty.
// when the receiver stalls the result register holds; the back waits with
// its next result and the queue then fills and stalls the shot channel
module ray_sphere_hit_with_damage #(
    parameter int QUEUE_DEPTH = rshd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    rshd_chan_if.sink   shot,
    rshd_chan_if.source result,
    rshd_chan_if.sink   cfg
);
    rshd_pkg::cfg_regs_t cfg_reg;

    // queue handshake
    logic            push;
    rshd_pkg::work_t push_data;
    logic            q_full;
    logic            pop;
    rshd_pkg::work_t pop_data;
    logic            q_not_empty;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.center_z      <= '0;
            cfg_reg.sphere_radius <= rshd_pkg::RADIUS_RESET;
            cfg_reg.max_health    <= rshd_pkg::HEALTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                rshd_pkg::CFG_CENTER_X:   cfg_reg.center_x      <= signed'(cfg.data.value);
                rshd_pkg::CFG_CENTER_Y:   cfg_reg.center_y      <= signed'(cfg.data.value);
                rshd_pkg::CFG_CENTER_Z:   cfg_reg.center_z      <= signed'(cfg.data.value);
                rshd_pkg::CFG_RADIUS:     cfg_reg.sphere_radius <= cfg.data.value[30:0];
                rshd_pkg::CFG_MAX_HEALTH: cfg_reg.max_health    <= cfg.data.value[15:0];
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    rshd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .shot      (shot),
        .cfg_regs  (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    rshd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    rshd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .result      (result)
    );
endmodule

@@ tb/sv/ray_sphere_hit_with_damage_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the ray sphere hit with damage block
module ray_sphere_hit_with_damage_test;
    import rshd_pkg::*;

    // ------------------------------------------------------------------
    // target tracker: keeps its own copy of registers and target state,
    // works out the result of each accepted item and checks the results
    // ------------------------------------------------------------------
    class target_tracker;
        cfg_regs_t   regs;
        logic [15:0] health;
        logic [15:0] hit_count;
        logic        dead;
        result_t     pending[$];
        int          errors;
        int          hits;
        int          kills;

        function new();
            regs.center_x      = '0;
            regs.center_y      = '0;
            regs.center_z      = '0;
            regs.sphere_radius = RADIUS_RESET;
            regs.max_health    = HEALTH_RESET;
            health    = HEALTH_RESET;
            hit_count = '0;
            dead      = 1'b0;
            errors    = 0;
            hits      = 0;
            kills     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_CENTER_X:   regs.center_x = val;
                CFG_CENTER_Y:   regs.center_y = val;
                CFG_CENTER_Z:   regs.center_z = val;
                CFG_RADIUS:     regs.sphere_radius = val[30:0];
                CFG_MAX_HEALTH: regs.max_health = val[15:0];
                default: ;
            endcase
        endfunction

        // bit-per-step floor square root of a 128 bit value
        function logic [63:0] isqrt(logic [127:0] v);
            logic [63:0]  r;
            logic [63:0]  t;
            logic [127:0] sq;
            r = '0;
            for (int i = 63; i >= 0; i--)
            begin
                t = r | (64'd1 << i);
                sq = 128'(t) * 128'(t);
                if (sq <= v)
                    r = t;
            end
            return r;
        endfunction

        // returns 1 on a hit within range and gives the distance
        function bit trace(shot_t s, output logic [30:0] hit_dist);
            logic signed [63:0]  ox, oy, oz, b, d, s64;
            logic [63:0]         mb;
            logic [127:0]        p, q;
            logic [63:0]         root;
            logic [63:0]         rng;
            hit_dist = '0;
            ox = 64'(s.origin_x) - 64'(regs.center_x);
            oy = 64'(s.origin_y) - 64'(regs.center_y);
            oz = 64'(s.origin_z) - 64'(regs.center_z);
            b  = ox * 64'(s.dir_x) + oy * 64'(s.dir_y) + oz * 64'(s.dir_z);
            mb = b < 0 ? -b : b;
            p  = 128'(mb) * 128'(mb)
               + ((128'(regs.sphere_radius) * 128'(regs.sphere_radius)) << DISC_SHIFT);
            q  = (128'(ox) * 128'(ox) + 128'(oy) * 128'(oy) + 128'(oz) * 128'(oz))
                 << DISC_SHIFT;
            if (p < q)
                return 0;
            root = isqrt(p - q);
            s64 = root;
            d = -b - s64;
            if (d < 0)
                d = -b + s64;
            if (d < 0)
                return 0;
            rng = 64'(s.max_range) << DIR_FRAC;
            if (64'(d) > rng)
                return 0;
            hit_dist = 31'(64'(d) >> DIR_FRAC);
            return 1;
        endfunction

        // an accepted item: apply it to the model state and queue its result
        function void note_item(shot_t s);
            result_t     r;
            logic [30:0] hit_dist;
            r = '0;
            if (s.action == ACT_RESET)
            begin
                health    = regs.max_health;
                hit_count = '0;
                dead      = 1'b0;
            end
            else if (!dead && trace(s, hit_dist))
            begin
                health    = (s.damage >= health) ? 16'd0 : health - s.damage;
                hit_count = hit_count + 16'd1;
                dead      = (health == 16'd0);
                r.hit            = 1'b1;
                r.eliminated     = dead;
                r.hit_distance   = hit_dist;
                r.damage_applied = s.damage;
                hits++;
                if (dead)
                    kills++;
            end
            r.health_left = health;
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.hit !== exp.hit)
            begin
                $error("hit: expected %0d got %0d", exp.hit, got.hit);
                errors++;
            end
            if (got.eliminated !== exp.eliminated)
            begin
                $error("eliminated: expected %0d got %0d", exp.eliminated, got.eliminated);
                errors++;
            end
            if (got.hit_distance !== exp.hit_distance)
            begin
                $error("hit_distance: expected %0d got %0d",
                       exp.hit_distance, got.hit_distance);
                errors++;
            end
            if (got.damage_applied !== exp.damage_applied)
            begin
                $error("damage_applied: expected %0d got %0d",
                       exp.damage_applied, got.damage_applied);
                errors++;
            end
            if (got.health_left !== exp.health_left)
            begin
                $error("health_left: expected %0d got %0d",
                       exp.health_left, got.health_left);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rshd_chan_if #(.T(shot_t))   shot_ch();
    rshd_chan_if #(.T(result_t)) result_ch();
    rshd_chan_if #(.T(cfg_wr_t)) cfg_ch();

    ray_sphere_hit_with_damage dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .shot   (shot_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    target_tracker tracker;
    int            items_sent;
    int            results_seen;
    bit            stall_long;    // receiver hold-off request
    bit            stall_done;

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // half of the gaps none at all, most of the rest short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(120, 10);
    endfunction

    // random 32 bit position, mostly near the sphere so rays can hit
    function automatic logic [31:0] near_pos(logic [31:0] c);
        if ($urandom_range(9) == 0)
            return $urandom;
        return c + 32'($signed($urandom_range(32'h000C_0000)) - 32'sh0006_0000);
    endfunction

    // a unit-ish direction; now and then any legal vector
    function automatic void rand_dir(output logic signed [15:0] x,
                                     output logic signed [15:0] y,
                                     output logic signed [15:0] z);
        int ax;
        if ($urandom_range(4) == 0)
        begin
            x = 16'($signed($urandom_range(32768)) - 16384);
            y = 16'($signed($urandom_range(32768)) - 16384);
            z = 16'($signed($urandom_range(32768)) - 16384);
            return;
        end
        ax = $urandom_range(2);
        x = '0;
        y = '0;
        z = '0;
        case (ax)
            0: x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            1: y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        endcase
        // small skew so the roots are not always exact
        if ($urandom_range(1))
            y = 16'(y + ($signed($urandom_range(800)) - 400));
    endfunction

    // aim a shot from a few meters out back toward the center
    function automatic shot_t aimed_shot();
        shot_t s;
        s.action = ACT_SHOT;
        rand_dir(s.dir_x, s.dir_y, s.dir_z);
        s.origin_x = near_pos(tracker.regs.center_x);
        s.origin_y = near_pos(tracker.regs.center_y);
        s.origin_z = near_pos(tracker.regs.center_z);
        // pull the origin back along the ray for a likely hit
        if ($urandom_range(1))
        begin
            s.origin_x = tracker.regs.center_x - 32'(s.dir_x) * 12;
            s.origin_y = tracker.regs.center_y - 32'(s.dir_y) * 12
                       + 32'($signed($urandom_range(65536)) - 32768);
            s.origin_z = tracker.regs.center_z - 32'(s.dir_z) * 12;
        end
        case ($urandom_range(3))
            0: s.max_range = 31'($urandom);
            1: s.max_range = 31'h7FFF_FFFF;
            default: s.max_range = 31'($urandom_range(32'h0008_0000));
        endcase
        s.damage = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
        return s;
    endfunction

    // one item through the shot channel, gap first
    task automatic send_item(shot_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            shot_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        shot_ch.valid <= 1'b1;
        shot_ch.data  <= s;
        @(posedge clk);
        while (!shot_ch.ready)
            @(posedge clk);
        tracker.note_item(s);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.write_reg(idx, val);
        @(negedge clk);
    endtask

    // let every expected result arrive, then keep idling so no stray result goes unseen
    task automatic drain();
        shot_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, logic [31:0] mh);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_MAX_HEALTH, mh);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic shot_t make_shot(int ox, int oy, int oz, int dx, int dy, int dz,
                                        logic [30:0] rng, logic [15:0] dmg);
        shot_t s;
        s.action   = ACT_SHOT;
        s.origin_x = ox;
        s.origin_y = oy;
        s.origin_z = oz;
        s.dir_x    = 16'(dx);
        s.dir_y    = 16'(dy);
        s.dir_z    = 16'(dz);
        s.max_range = rng;
        s.damage   = dmg;
        return s;
    endfunction

    function automatic shot_t make_reset();
        shot_t s;
        s = shot_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        s.action = ACT_RESET;
        return s;
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_long)
            result_ch.ready <= 1'b0;
        else if ($urandom_range(99) < 25)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= 1'b1;
    end

    // long hold-off counted in its own process
    initial
    begin
        stall_long = 1'b0;
        stall_done = 1'b0;
        wait (items_sent >= 300);
        @(negedge clk);
        stall_long = 1'b1;
        repeat (600) @(negedge clk);
        stall_long = 1'b0;
        stall_done = 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            tracker.check_result(result_ch.data);
            results_seen++;
        end
    end

    // stimulus
    initial
    begin
        shot_t s;
        tracker      = new();
        items_sent   = 0;
        results_seen = 0;
        rst_n           = 1'b0;
        shot_ch.valid   = 1'b0;
        shot_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // directed: default unit sphere at the origin
        send_item(make_shot(-5 << 16, 0, 0, 16384, 0, 0, 31'h7FFF_FFFF, 16'd1000));
        send_item(make_shot(0, 0, 0, 0, 16384, 0, 31'h7FFF_FFFF, 16'd0));       // inside: far root
        send_item(make_shot(5 << 16, 0, 0, 16384, 0, 0, 31'h7FFF_FFFF, 16'd5)); // behind
        send_item(make_shot(-5 << 16, 2 << 16, 0, 16384, 0, 0, 31'h7FFF_FFFF, 16'd5)); // miss
        send_item(make_shot(-5 << 16, 0, 0, 16384, 0, 0, 31'd0, 16'd5));        // out of range
        send_item(make_shot(-5 << 16, 0, 0, 16384, 0, 0, 31'd4 << 16, 16'd5)); // range edge
        send_item(make_shot(-5 << 16, 1 << 16, 0, 16384, 0, 0, 31'h7FFF_FFFF, 16'd7)); // tangent
        send_item(make_shot(0, 0, -3 << 16, -16384, -16384, 16384, 31'h7FFF_FFFF, 16'd9));
        send_item(make_shot(0, 0, -3 << 16, 16384, 16384, 16384, 31'h7FFF_FFFF, 16'd9));
        send_item(make_shot(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            -16384, 16384, -16384, 31'h7FFF_FFFF, 16'hFFFF));    // extremes
        send_item(make_shot(0, -4 << 16, 0, 0, 16384, 0, 31'h7FFF_FFFF, 16'hFFFF)); // overkill
        send_item(make_shot(0, -4 << 16, 0, 0, 16384, 0, 31'h7FFF_FFFF, 16'd1));    // dead target
        send_item(make_reset());
        send_item(make_shot(0, -4 << 16, 0, 0, 16384, 0, 31'h7FFF_FFFF, 16'd100));
        drain();

        // zero max health: live target with zero health, a hit still counts
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        send_item(make_shot(32'h7FFF_FFFF - (3 << 16), 32'h8000_0000, 0,
                            16384, 0, 0, 31'h7FFF_FFFF, 16'd3));
        send_item(make_reset());
        send_item(make_shot(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 31'h7FFF_FFFF, 16'd0));
        send_item(make_reset());
        drain();

        // biggest radius and health
        write_all(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'hFFFF);
        send_item(make_reset());
        send_item(make_shot(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16384, 16384, 16384, 31'h7FFF_FFFF, 16'd2));
        send_item(make_shot(1, 2, 3, 0, 0, 0, 31'h7FFF_FFFF, 16'd2));
        drain();

        // random phases with fresh register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd1);
            else
                write_all($urandom, $urandom, $urandom,
                          (ph % 2) ? $urandom_range(32'h0004_0000, 32'h0000_4000) : $urandom,
                          $urandom_range(1) ? $urandom_range(20000) : $urandom);
            for (int k = 0; k < 235; k++)
            begin
                if ($urandom_range(19) == 0)
                    s = make_reset();
                else if ($urandom_range(9) == 0)
                    s = make_shot($urandom, $urandom, $urandom,
                                  $signed($urandom_range(32768)) - 16384,
                                  $signed($urandom_range(32768)) - 16384,
                                  $signed($urandom_range(32768)) - 16384,
                                  31'($urandom), 16'($urandom));
                else
                    s = aimed_shot();
                send_item(s);
            end
            drain();
        end

        wait (stall_done);
        drain();
        $display("covered %0d items, %0d results, %0d hits, %0d eliminations",
                 items_sent, results_seen, tracker.hits, tracker.kills);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("TEST PASSED");
        else
        begin
            if (tracker.pending.size() != 0)
                $error("%0d results never arrived", tracker.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
